FILE: rtl/whole_word_fixed_string_search_core_macros.svh
// Assertion macros shared by the search core RTL.
// Each macro expects clk and rst_n to be visible in the enclosing module.
`ifndef WHOLE_WORD_FIXED_STRING_SEARCH_CORE_MACROS_SVH
`define WHOLE_WORD_FIXED_STRING_SEARCH_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WWFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WWFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wwfs_pkg.sv
// Shared constants, types and helper functions of the fixed string search core.
// No dependencies; every RTL module and interface imports this package.
package wwfs_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_LINE_DEF    = 4096;

    localparam int BYTE_W     = 8;
    localparam int SEARCH_W   = 12;
    localparam int END_W      = 13;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int PAT_LEN_W  = 6;
    localparam int PAT_WORDS  = 4;
    localparam int PAT_BYTES  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WHOLE_WORD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WHOLE_LINE     = 3'd6;

    localparam logic [BYTE_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_DIGIT_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIGIT_9    = 8'h39;

    typedef struct packed {
        logic eq_old;
        logic eq_new;
        logic is_word;
    } cell_status_t;

    typedef struct packed {
        logic                found;
        logic [SEARCH_W-1:0] match_start;
        logic [END_W-1:0]    match_end;
    } result_t;

    function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
               (c == CH_UNDERSCORE);
    endfunction

endpackage

FILE: rtl/wwfs_if.sv
// Valid/ready channel interfaces for the text byte input and the result output.
// Depends on wwfs_pkg for the field widths.
interface wwfs_text_if
    import wwfs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   line_byte;
    logic                line_first;
    logic                line_last;
    logic [SEARCH_W-1:0] search_start;

    modport source (output valid, line_byte, line_first, line_last, search_start,
                    input ready);
    modport sink (input valid, line_byte, line_first, line_last, search_start,
                  output ready);
endinterface

interface wwfs_result_if
    import wwfs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                found;
    logic [SEARCH_W-1:0] match_start;
    logic [END_W-1:0]    match_end;

    modport source (output valid, found, match_start, match_end, input ready);
    modport sink (input valid, found, match_start, match_end, output ready);
endinterface

FILE: rtl/wwfs_cell.sv
// One cell of the byte window: holds one text byte and compares it to its pattern byte.
// Depends on wwfs_pkg for the status struct and the word class function.
module wwfs_cell
    import wwfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic              active,
    input  logic [BYTE_W-1:0] left_byte,
    input  logic [BYTE_W-1:0] pat_byte,
    output logic [BYTE_W-1:0] byte_q,
    output cell_status_t      status
);

    logic [BYTE_W-1:0] byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (shift)
        begin
            byte_reg <= left_byte;
        end
    end

    assign byte_q         = byte_reg;
    assign status.eq_old  = !active || (byte_reg == pat_byte);
    assign status.eq_new  = !active || (left_byte == pat_byte);
    assign status.is_word = is_word_char(byte_reg);

endmodule

FILE: rtl/wwfs_outbuf.sv
// Two-entry result buffer: an output register and a skid register behind it.
// Depends on wwfs_pkg, wwfs_if and the assertion macro header.
`include "whole_word_fixed_string_search_core_macros.svh"

module wwfs_outbuf
    import wwfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_t      push_data,
    output logic         ready,
    wwfs_result_if.source result
);

    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign pop   = out_valid_reg && result.ready;
    assign ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                if (!out_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.found       = out_reg.found;
    assign result.match_start = out_reg.match_start;
    assign result.match_end   = out_reg.match_end;

    `WWFS_ASSERT_SAME(a_skid_behind_head, skid_valid_reg, out_valid_reg, "skid word without head word")
    `WWFS_ASSERT_SAME(a_no_push_when_full, push, !skid_valid_reg, "result pushed into full buffer")

endmodule

FILE: rtl/whole_word_fixed_string_search_core.sv
// Fixed string search core: text bytes in, at most one result word per line.
// The result word is pushed into the output buffer by the byte that decides it.
// One byte per cycle while the result buffer has room, set by the parallel compare in the cell row.
// Reset clears the window, line state, config and result buffer valid flags; buffer data has no reset.
// Depends on wwfs_pkg, wwfs_if, wwfs_cell, wwfs_outbuf and the macro header.
`include "whole_word_fixed_string_search_core_macros.svh"

module whole_word_fixed_string_search_core
    import wwfs_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_LINE    = MAX_LINE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    wwfs_text_if.sink             text,
    wwfs_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LENW   = $clog2(MAX_PATTERN + 1);
    localparam int PW_RAW = $clog2(MAX_LINE + MAX_PATTERN + 2);
    localparam int PW     = (PW_RAW > END_W) ? PW_RAW : END_W;
    localparam logic [PW-1:0] LINE_LIMIT = PW'(MAX_LINE);

    logic [PAT_LEN_W-1:0]  pattern_length_reg;
    logic [CFG_DATA_W-1:0] pattern_reg [PAT_WORDS];
    logic                  whole_word_reg;
    logic                  whole_line_reg;

    logic [PW-1:0]       line_pos_reg;
    logic [PW-1:0]       line_pos_next;
    logic [SEARCH_W-1:0] start_reg;
    logic [PW-1:0]       resume_reg;
    logic [PW-1:0]       resume_next;
    logic                line_done_reg;

    logic [PAT_WORDS*CFG_DATA_W-1:0] pattern_flat;
    logic [LENW-1:0]     len_eff;
    logic [LENW-1:0]     len_m1;
    logic [PW-1:0]       len_p;
    logic [BYTE_W-1:0]   rp [MAX_PATTERN+1];
    logic [BYTE_W-1:0]   window [MAX_PATTERN+1];
    cell_status_t        status [MAX_PATTERN+1];
    logic [MAX_PATTERN:0] eq_old_bits;
    logic [MAX_PATTERN:0] eq_new_bits;
    logic [MAX_PATTERN:0] word_bits;

    logic                accept;
    logic                process;
    logic                buf_ready;
    logic [PW-1:0]       p;
    logic [PW-1:0]       p1;
    logic [PW-1:0]       q1;
    logic [PW-1:0]       q2;
    logic [PW-1:0]       resume_eff;
    logic [PW-1:0]       resume1;
    logic [SEARCH_W-1:0] start_eff;
    logic                needs_check;
    logic                m1;
    logic                m2;
    logic                ok1;
    logic                ok2;
    logic                acc1;
    logic                acc2;
    logic                found;
    logic [PW-1:0]       q_sel;
    logic [PW-1:0]       rel;
    logic [PW-1:0]       rel_end;
    logic                push;
    result_t             push_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= PAT_LEN_W'(1);
            for (int k = 0; k < PAT_WORDS; k++)
            begin
                pattern_reg[k] <= '0;
            end
            whole_word_reg <= 1'b0;
            whole_line_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[PAT_LEN_W-1:0];
                REG_PATTERN_WORD0:  pattern_reg[0] <= cfg_data;
                REG_PATTERN_WORD1:  pattern_reg[1] <= cfg_data;
                REG_PATTERN_WORD2:  pattern_reg[2] <= cfg_data;
                REG_PATTERN_WORD3:  pattern_reg[3] <= cfg_data;
                REG_WHOLE_WORD:     whole_word_reg <= cfg_data[0];
                REG_WHOLE_LINE:     whole_line_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign pattern_flat = {pattern_reg[3], pattern_reg[2], pattern_reg[1], pattern_reg[0]};

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_eff = LENW'(1);
        end
        else if (int'(pattern_length_reg) > MAX_PATTERN)
        begin
            len_eff = LENW'(MAX_PATTERN);
        end
        else
        begin
            len_eff = LENW'(pattern_length_reg);
        end
    end

    assign len_m1 = len_eff - LENW'(1);
    assign len_p  = PW'(len_eff);

    // Cell j compares against pattern byte len-1-j, so a match ending at the
    // newest byte shows up as every active cell agreeing.
    always_comb
    begin
        logic [6:0] idx;
        idx = '0;
        for (int j = 0; j <= MAX_PATTERN; j++)
        begin
            idx = 7'(len_m1) - 7'(j);
            if ((j < int'(len_eff)) && (idx < 7'(PAT_BYTES)))
            begin
                rp[j] = pattern_flat[{idx[4:0], 3'b000} +: BYTE_W];
            end
            else
            begin
                rp[j] = '0;
            end
        end
    end

    assign accept  = text.valid && text.ready;
    assign process = accept && (text.line_first || !line_done_reg);

    genvar g;
    generate
        for (g = 0; g <= MAX_PATTERN; g++)
        begin : g_cell
            wwfs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (process),
                .active    (g < int'(len_eff)),
                .left_byte ((g == 0) ? text.line_byte : window[(g == 0) ? 0 : g - 1]),
                .pat_byte  (rp[g]),
                .byte_q    (window[g]),
                .status    (status[g])
            );
            assign eq_old_bits[g] = status[g].eq_old;
            assign eq_new_bits[g] = status[g].eq_new;
            assign word_bits[g]   = status[g].is_word;
        end
    endgenerate

    assign p          = text.line_first ? '0 : line_pos_reg;
    assign p1         = p + PW'(1);
    assign resume_eff = text.line_first ? PW'(text.search_start) : resume_reg;
    assign start_eff  = text.line_first ? text.search_start : start_reg;
    assign q1         = p - len_p;
    assign q2         = p1 - len_p;

    assign needs_check = whole_word_reg || whole_line_reg;

    always_comb
    begin
        logic fail_prev1;
        logic fail_next1;
        logic fail_prev2;
        fail_prev1 = (q1 != '0) && (whole_line_reg || word_bits[len_eff]);
        fail_next1 = (text.line_byte != CH_NEWLINE) &&
                     (whole_line_reg || is_word_char(text.line_byte));
        fail_prev2 = (q2 != '0) && (whole_line_reg || word_bits[len_m1]);
        ok1 = !needs_check || (!fail_prev1 && !fail_next1);
        ok2 = !needs_check || !fail_prev2;
    end

    // The candidate ending at the previous byte is judged first; a rejected
    // candidate pushes the resume point to one pattern length past its start.
    assign m1      = (p >= len_p) && (p <= LINE_LIMIT) && (q1 >= resume_eff) && (&eq_old_bits);
    assign acc1    = m1 && ok1;
    assign resume1 = (m1 && !ok1) ? p : resume_eff;

    assign m2 = !acc1 && text.line_last && (p1 >= len_p) && (p1 <= LINE_LIMIT) &&
                (q2 >= resume1) && (&eq_new_bits);
    assign acc2        = m2 && ok2;
    assign resume_next = (m2 && !ok2) ? p1 : resume1;

    assign found   = acc1 || acc2;
    assign q_sel   = acc1 ? q1 : q2;
    assign rel     = q_sel - PW'(start_eff);
    assign rel_end = rel + len_p;

    assign line_pos_next = (p <= LINE_LIMIT) ? p1 : p;

    assign push                  = process && (found || text.line_last);
    assign push_data.found       = found;
    assign push_data.match_start = found ? rel[SEARCH_W-1:0] : '0;
    assign push_data.match_end   = found ? rel_end[END_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_reg  <= '0;
            start_reg     <= '0;
            resume_reg    <= '0;
            line_done_reg <= 1'b0;
        end
        else if (process)
        begin
            line_pos_reg  <= line_pos_next;
            start_reg     <= start_eff;
            resume_reg    <= resume_next;
            line_done_reg <= found || text.line_last;
        end
    end

    wwfs_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .ready     (buf_ready),
        .result    (result)
    );

    assign text.ready = buf_ready;

    `WWFS_ASSERT_NEXT(a_done_after_result, push, line_done_reg, "line still open after its result")
    `WWFS_ASSERT_SAME(a_resume_after_start, 1'b1, resume_reg >= PW'(start_reg), "resume point before start")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for whole_word_fixed_string_search_core: streams text lines
// through the byte channel and checks every result word against a built-in predictor.
// Depends on wwfs_pkg, wwfs_if and the search core RTL.
module tb_top;
    import wwfs_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_WORDS   = 215;
    localparam int PRINT_LIMIT   = 40;
    localparam int WIN_DEPTH     = MAX_PATTERN_DEF + 2;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LOWER_B = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LOWER_X = 8'h78;

    typedef struct {
        logic [BYTE_W-1:0]   line_byte;
        logic                line_first;
        logic                line_last;
        logic [SEARCH_W-1:0] search_start;
    } text_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wwfs_text_if   text_ch ();
    wwfs_result_if result_ch ();

    whole_word_fixed_string_search_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    text_word_t        pending_words[$];
    result_t           expected_results[$];
    logic [BYTE_W-1:0] line_bytes[$];
    int                words_queued;
    int                words_taken;
    int                error_count;
    int                cycle_count;
    int                send_idle_pct;
    int                recv_stall_pct;

    logic [PAT_LEN_W-1:0]  cfg_pat_len;
    logic [CFG_DATA_W-1:0] cfg_pat_word [PAT_WORDS];
    logic                  cfg_whole_word;
    logic                  cfg_whole_line;

    logic [BYTE_W-1:0] window [WIN_DEPTH];
    int unsigned       line_pos;
    int unsigned       start_off;
    int unsigned       resume_pos;
    bit                line_closed;

    always
    begin
        #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int unsigned used_length();
        if (cfg_pat_len == '0)
            return 1;
        if (int'(cfg_pat_len) > MAX_PATTERN_DEF)
            return MAX_PATTERN_DEF;
        return 32'(cfg_pat_len);
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input int unsigned i);
        return cfg_pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic bit word_char(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] folded;
        folded = c | 8'h20;
        return (folded >= CH_LOWER_A && folded <= CH_LOWER_Z) ||
               (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || c == CH_UNDERSCORE;
    endfunction

    // A rejected candidate pushes the resume point one pattern length past its start.
    function automatic bit take_candidate(input int unsigned q, input int unsigned base,
                                          input int unsigned len, input bit at_end);
        int unsigned       i;
        bit                ok;
        logic [BYTE_W-1:0] follower;
        ok = 1'b1;
        if (q < resume_pos)
            return 1'b0;
        for (i = 0; i < len; i++)
        begin
            if (window[base - i] != pattern_byte(i))
                return 1'b0;
        end
        if (cfg_whole_word || cfg_whole_line)
        begin
            if (q > 0 && (cfg_whole_line || word_char(window[base + 1])))
                ok = 1'b0;
            if (ok && !at_end)
            begin
                follower = window[base - len];
                if (follower != CH_NEWLINE && (cfg_whole_line || word_char(follower)))
                    ok = 1'b0;
            end
        end
        if (!ok)
        begin
            resume_pos = q + len;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit predict_word(input text_word_t w, output result_t r);
        int unsigned len;
        int unsigned p;
        int unsigned q;
        int unsigned rel;
        bit          hit;
        int          k;
        len = used_length();
        hit = 1'b0;
        q = 0;
        r = '0;
        if (w.line_first)
        begin
            line_pos = 0;
            start_off = 32'(w.search_start);
            resume_pos = start_off;
            line_closed = 1'b0;
        end
        else if (line_closed)
            return 1'b0;
        for (k = WIN_DEPTH - 1; k > 0; k--)
            window[k] = window[k - 1];
        window[0] = w.line_byte;
        p = line_pos;
        if (p >= len && p <= MAX_LINE_DEF)
        begin
            q = p - len;
            hit = take_candidate(q, len, len, 1'b0);
        end
        if (!hit && w.line_last && p + 1 >= len && p + 1 <= MAX_LINE_DEF)
        begin
            q = p + 1 - len;
            hit = take_candidate(q, len - 1, len, 1'b1);
        end
        if (line_pos <= MAX_LINE_DEF)
            line_pos++;
        if (hit)
        begin
            rel = q - start_off;
            r.found = 1'b1;
            r.match_start = SEARCH_W'(rel);
            r.match_end = END_W'(rel + len);
            line_closed = 1'b1;
            return 1'b1;
        end
        if (w.line_last)
        begin
            line_closed = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_char();
        case ($urandom_range(9))
            0, 1, 2: return CH_LOWER_A;
            3, 4:    return CH_LOWER_B;
            5:       return CH_UNDERSCORE;
            6:       return CH_DIGIT_9;
            7:       return CH_SPACE;
            8:       return 8'h00;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] filler_byte();
        case ($urandom_range(11))
            0, 1, 2: return pattern_byte($urandom_range(used_length() - 1));
            3:       return CH_SPACE;
            4:       return CH_NEWLINE;
            5:       return CH_UNDERSCORE;
            6:       return CH_LOWER_X;
            7:       return CH_DIGIT_0;
            8:       return CH_UPPER_Z;
            9:       return 8'h00;
            10:      return 8'hFF;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [SEARCH_W-1:0] pick_start(input int n);
        case ($urandom_range(9))
            7, 8:    return SEARCH_W'($urandom_range(n));
            9:       return SEARCH_W'($urandom_range(4095));
            default: return '0;
        endcase
    endfunction

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("tb_top: error at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic put_word(input logic [BYTE_W-1:0] b, input bit first, input bit last,
                            input logic [SEARCH_W-1:0] start);
        text_word_t w;
        w.line_byte = b;
        w.line_first = first;
        w.line_last = last;
        w.search_start = start;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_line(input logic [SEARCH_W-1:0] start, input bit closed);
        int i;
        for (i = 0; i < line_bytes.size(); i++)
        begin
            put_word(line_bytes[i], i == 0, closed && i == line_bytes.size() - 1,
                     (i == 0) ? start : SEARCH_W'($urandom));
        end
    endtask

    task automatic append_pattern(input bit mutate);
        int unsigned i;
        int unsigned spot;
        spot = $urandom_range(used_length() - 1);
        for (i = 0; i < used_length(); i++)
        begin
            if (mutate && i == spot)
                line_bytes.push_back(filler_byte());
            else
                line_bytes.push_back(pattern_byte(i));
        end
    endtask

    task automatic choose_pattern(input int len, input bit ww, input bit wl);
        int i;
        cfg_pat_len = PAT_LEN_W'(len);
        cfg_whole_word = ww;
        cfg_whole_line = wl;
        for (i = 0; i < PAT_WORDS; i++)
            cfg_pat_word[i] = {$urandom, $urandom};
        for (i = 0; i < used_length(); i++)
            cfg_pat_word[i / 8][(i % 8) * 8 +: 8] = pattern_char();
    endtask

    task automatic load_registers();
        int i;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data <= CFG_DATA_W'(cfg_pat_len);
        for (i = 0; i < PAT_WORDS; i++)
        begin
            @(posedge clk);
            cfg_index <= REG_PATTERN_WORD0 + CFG_IDX_W'(i);
            cfg_data <= cfg_pat_word[i];
        end
        @(posedge clk);
        cfg_index <= REG_WHOLE_WORD;
        cfg_data <= CFG_DATA_W'(cfg_whole_word);
        @(posedge clk);
        cfg_index <= REG_WHOLE_LINE;
        cfg_data <= CFG_DATA_W'(cfg_whole_line);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idle(input int mode);
        send_idle_pct = (mode == IDLE_SEND) ? 86 : (mode == IDLE_BOTH) ? 26 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 86 : (mode == IDLE_BOTH) ? 26 : 0;
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        int stop;
        int kind;
        int n;
        int j;
        stop = words_queued + count;
        while (words_queued < stop)
        begin
            kind = $urandom_range(19);
            line_bytes.delete();
            if (kind < 14)
            begin
                n = $urandom_range(1, 2 * used_length() + 10);
                while (line_bytes.size() < n)
                begin
                    if ($urandom_range(3) == 0)
                        append_pattern($urandom_range(4) == 0);
                    else
                        line_bytes.push_back(filler_byte());
                end
                push_line(pick_start(n), kind < 12);
            end
            else if (kind < 18)
            begin
                n = $urandom_range(2);
                for (j = 0; j < n; j++)
                    line_bytes.push_back(filler_byte());
                append_pattern($urandom_range(5) == 0);
                case ($urandom_range(3))
                    0:       line_bytes.push_back(CH_NEWLINE);
                    1:       line_bytes.push_back(filler_byte());
                    default: ;
                endcase
                if ($urandom_range(2) == 0)
                    line_bytes.push_back(filler_byte());
                push_line(pick_start(line_bytes.size()), 1'b1);
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (j = 0; j < n; j++)
                begin
                    put_word(filler_byte(), $urandom_range(3) == 0, $urandom_range(3) == 0,
                             SEARCH_W'($urandom_range(4095)));
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : drive_text
        text_word_t w;
        if (!rst_n)
            text_ch.valid <= 1'b0;
        else if (!text_ch.valid || text_ch.ready)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = pending_words.pop_front();
                text_ch.valid <= 1'b1;
                text_ch.line_byte <= w.line_byte;
                text_ch.line_first <= w.line_first;
                text_ch.line_last <= w.line_last;
                text_ch.search_start <= w.search_start;
            end
            else
                text_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        text_word_t w;
        result_t    r;
        result_t    want;
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                w.line_byte = text_ch.line_byte;
                w.line_first = text_ch.line_first;
                w.line_last = text_ch.line_last;
                w.search_start = text_ch.search_start;
                if (predict_word(w, r))
                    expected_results.push_back(r);
                words_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_error($sformatf("result word found=%0d start=%0d end=%0d not expected",
                                           result_ch.found, result_ch.match_start,
                                           result_ch.match_end));
                else
                begin
                    want = expected_results.pop_front();
                    if (result_ch.found !== want.found)
                        report_error($sformatf("found %0d, expected %0d",
                                               result_ch.found, want.found));
                    if (result_ch.match_start !== want.match_start)
                        report_error($sformatf("match_start %0d, expected %0d",
                                               result_ch.match_start, want.match_start));
                    if (result_ch.match_end !== want.match_end)
                        report_error($sformatf("match_end %0d, expected %0d",
                                               result_ch.match_end, want.match_end));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin : run_test
        int ph;
        int k;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        text_ch.valid = 1'b0;
        text_ch.line_byte = '0;
        text_ch.line_first = 1'b0;
        text_ch.line_last = 1'b0;
        text_ch.search_start = '0;
        result_ch.ready = 1'b0;
        words_queued = 0;
        words_taken = 0;
        error_count = 0;
        cycle_count = 0;
        cfg_pat_len = PAT_LEN_W'(1);
        cfg_whole_word = 1'b0;
        cfg_whole_line = 1'b0;
        for (k = 0; k < PAT_WORDS; k++)
            cfg_pat_word[k] = '0;
        for (k = 0; k < WIN_DEPTH; k++)
            window[k] = '0;
        line_pos = 0;
        start_off = 0;
        resume_pos = 0;
        line_closed = 1'b0;
        set_idle(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Right after reset a line is already open at offset zero.
        put_word(CH_LOWER_X, 1'b0, 1'b0, '0);
        put_word(8'h00, 1'b0, 1'b1, '0);
        wait_drained();

        choose_pattern(2, 1'b1, 1'b0);
        cfg_pat_word[0][15:0] = {CH_LOWER_B, CH_LOWER_A};
        load_registers();
        put_word(CH_LOWER_A, 1'b1, 1'b0, '0);
        put_word(CH_LOWER_B, 1'b0, 1'b1, '0);
        put_word(CH_LOWER_A, 1'b1, 1'b0, 12'd1);
        put_word(CH_LOWER_A, 1'b0, 1'b0, '0);
        put_word(CH_LOWER_B, 1'b0, 1'b0, '0);
        put_word(CH_SPACE, 1'b0, 1'b0, '0);
        put_word(CH_LOWER_A, 1'b0, 1'b0, '0);
        put_word(CH_LOWER_B, 1'b0, 1'b1, '0);
        put_word(CH_LOWER_A, 1'b1, 1'b0, 12'd4095);
        put_word(CH_LOWER_B, 1'b0, 1'b1, '0);
        put_word(CH_LOWER_A, 1'b0, 1'b0, '0);
        put_word(CH_LOWER_B, 1'b0, 1'b0, '0);
        put_word(CH_LOWER_A, 1'b1, 1'b0, '0);
        put_word(CH_LOWER_A, 1'b1, 1'b0, '0);
        put_word(CH_LOWER_B, 1'b0, 1'b0, '0);
        put_word(CH_NEWLINE, 1'b0, 1'b1, '0);
        wait_drained();

        choose_pattern(0, 1'b0, 1'b1);
        cfg_pat_word[0][7:0] = 8'h00;
        load_registers();
        put_word(8'h00, 1'b1, 1'b1, '0);
        put_word(8'h00, 1'b1, 1'b0, '0);
        put_word(CH_NEWLINE, 1'b0, 1'b1, '0);
        put_word(CH_LOWER_X, 1'b1, 1'b0, '0);
        put_word(8'h00, 1'b0, 1'b1, '0);
        wait_drained();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       choose_pattern(1, 1'b0, 1'b0);
                1:       choose_pattern(32, 1'b1, 1'b0);
                2:       choose_pattern(63, 1'b0, 1'b1);
                3:       choose_pattern(0, 1'b1, 1'b1);
                default: choose_pattern($urandom_range(1, 8), $urandom_range(1) == 1,
                                        $urandom_range(3) == 0);
            endcase
            load_registers();
            set_idle(ph % 4);
            if (ph == 3)
            begin
                queue_random(PHASE_WORDS / 2);
                wait_drained();
                queue_random(PHASE_WORDS / 2);
            end
            else
                queue_random(PHASE_WORDS);
            wait_drained();
        end

        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/wwfs_pkg.sv
rtl/wwfs_if.sv
rtl/wwfs_cell.sv
rtl/wwfs_outbuf.sv
rtl/whole_word_fixed_string_search_core.sv
tb/sv/tb_top.sv
